// File: rtl/sls_pkg.sv
package sls_pkg;

  // Counter width default and the fixed width of reported counts
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned OUT_W           = 16;
  localparam int unsigned OUT_MAX         = 65535;

  // Keyword table size, word-position width and table index width
  localparam int unsigned NUM_KW  = 6;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned KW_IDX_W = 3;

  // Characters the scanner cares about
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_VTAB      = 8'h0B;
  localparam logic [7:0] CH_FFEED     = 8'h0C;
  localparam logic [7:0] CH_CRET      = 8'h0D;

  localparam int unsigned TAB_STEP = 4;

  // Item kinds on the input channel
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Configuration register map
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_INDENT_EN  = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_CONT_EN    = 4'h4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LINE_LIMIT = 4'h8;
  localparam logic [15:0] LINE_LIMIT_RST = 16'd10000;

  typedef enum logic [2:0] {
    KW_NONE,
    KW_FOR,
    KW_WHILE,
    KW_UNTIL,
    KW_IF,
    KW_CASE,
    KW_FUNCTION
  } kw_code_t;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_WORD,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic        indent_enable;
    logic        continuation_enable;
    logic [15:0] line_limit;
  } cfg_t;

  typedef struct packed {
    logic [OUT_W-1:0] line_index;
    logic [OUT_W-1:0] line_bytes;
    logic [OUT_W-1:0] indent_width;
    logic             continues;
    kw_code_t         keyword_code;
    logic             too_many_lines;
    logic             final_line;
  } line_res_t;

  // Whitespace: space, tab, VT, FF, CR
  function automatic logic is_ws(logic [7:0] b);
    is_ws = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VTAB) ||
            (b == CH_FFEED) || (b == CH_CRET);
  endfunction

  // Keyword length by table slot (slot i reports code i+1)
  function automatic logic [POS_W-1:0] kw_len(logic [KW_IDX_W-1:0] idx);
    case (idx)
      3'd0:    kw_len = 4'd3;
      3'd1:    kw_len = 4'd5;
      3'd2:    kw_len = 4'd5;
      3'd3:    kw_len = 4'd2;
      3'd4:    kw_len = 4'd4;
      3'd5:    kw_len = 4'd8;
      default: kw_len = 4'd0;
    endcase
  endfunction

  // Keyword character at a position, text left-aligned in 64 bits
  function automatic logic [7:0] kw_char(logic [KW_IDX_W-1:0] idx, logic [2:0] pos);
    logic [63:0] txt;
    case (idx)
      3'd0:    txt = {"for", 40'h0};
      3'd1:    txt = {"while", 24'h0};
      3'd2:    txt = {"until", 24'h0};
      3'd3:    txt = {"if", 48'h0};
      3'd4:    txt = {"case", 32'h0};
      3'd5:    txt = "function";
      default: txt = '0;
    endcase
    kw_char = txt[{3'd7 - pos, 3'b000} +: 8];
  endfunction

endpackage

// File: rtl/sls_ifs.sv
interface sls_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] text_byte;

  modport source (output valid, func, text_byte, input ready);
  modport sink   (input valid, func, text_byte, output ready);
endinterface

interface sls_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] line_index;
  logic [15:0] line_bytes;
  logic [15:0] indent_width;
  logic        continues;
  logic [2:0]  keyword_code;
  logic        too_many_lines;
  logic        final_line;

  modport source (output valid, line_index, line_bytes, indent_width, continues,
                  keyword_code, too_many_lines, final_line, input ready);
  modport sink   (input valid, line_index, line_bytes, indent_width, continues,
                  keyword_code, too_many_lines, final_line, output ready);
endinterface

// File: rtl/shell_line_splitter_scanner.sv
// Shell line splitter: takes one beat per cycle on in_ch (a text byte, or an end-of-command
// marker) and emits one beat on out_ch for every newline byte and every end marker,
// describing the line just closed: index, length, indent, continuation flag, leading
// keyword, overflow against the line limit and whether the end marker closed it. Throughput
// is one item per clock with no bubbles; the only thing that stops intake is a result beat
// waiting on out_ch while out_ch.ready is low. An item passes the input register, then
// the line-state update and result register. Counters are COUNT_WIDTH bits and saturate;
// reported counts are capped at 65535. The user must write configuration through the APB
// port only while no item is in flight; the block itself does not enforce this.
module shell_line_splitter_scanner #(
  parameter int unsigned COUNT_WIDTH = sls_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sls_in_if.sink                          in_ch,
  sls_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sls_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sls_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sls_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import sls_pkg::*;

  cfg_t       cfg;
  logic       s1_vld_r;
  logic       s1_func_r;
  logic [7:0] s1_byte_r;
  logic       out_vld_r;
  line_res_t  out_res_r;
  line_res_t  res;
  logic       close;
  logic       adv;
  logic       step;

  sls_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sls_line_scan #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .func      (s1_func_r),
    .text_byte (s1_byte_r),
    .cfg       (cfg),
    .close     (close),
    .res       (res)
  );

  // Hold everything only while a result beat is stalled
  assign adv         = !out_vld_r || out_ch.ready;
  assign step        = s1_vld_r && adv;
  assign in_ch.ready = adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ch.valid) begin
      s1_func_r <= in_ch.func;
      s1_byte_r <= in_ch.text_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r && close;
    end
  end

  always_ff @(posedge clk) begin
    if (step && close) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.line_index     = out_res_r.line_index;
  assign out_ch.line_bytes     = out_res_r.line_bytes;
  assign out_ch.indent_width   = out_res_r.indent_width;
  assign out_ch.continues      = out_res_r.continues;
  assign out_ch.keyword_code   = out_res_r.keyword_code;
  assign out_ch.too_many_lines = out_res_r.too_many_lines;
  assign out_ch.final_line     = out_res_r.final_line;

  // Intake stops only behind a stalled result beat
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_vld_r && !out_ch.ready))
    else $error("input stalled without a waiting result beat");

  // A new result beat follows a line-closing item in the input register
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_vld_r && close))
    else $error("result beat without a closing item");

  // Overflow flag agrees with the reported line index
  a_overflow_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.too_many_lines == (out_res_r.line_index >= cfg.line_limit)))
    else $error("too_many_lines inconsistent with line_index");

endmodule

// File: rtl/sls_cfg_regs.sv
module sls_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sls_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sls_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sls_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output sls_pkg::cfg_t                   cfg
);
  import sls_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.indent_enable       <= 1'b1;
      cfg_r.continuation_enable <= 1'b1;
      cfg_r.line_limit          <= LINE_LIMIT_RST;
    end else if (wr_en) begin
      case (paddr)
        ADDR_INDENT_EN:  cfg_r.indent_enable       <= pwdata[0];
        ADDR_CONT_EN:    cfg_r.continuation_enable <= pwdata[0];
        ADDR_LINE_LIMIT: cfg_r.line_limit          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (paddr)
      ADDR_INDENT_EN:  prdata[0]    = cfg_r.indent_enable;
      ADDR_CONT_EN:    prdata[0]    = cfg_r.continuation_enable;
      ADDR_LINE_LIMIT: prdata[15:0] = cfg_r.line_limit;
      default:         prdata       = '0;
    endcase
  end

endmodule

// File: rtl/sls_line_scan.sv
module sls_line_scan #(
  parameter int unsigned COUNT_WIDTH = sls_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 func,
  input  logic [7:0]           text_byte,
  input  sls_pkg::cfg_t        cfg,
  output logic                 close,
  output sls_pkg::line_res_t   res
);
  import sls_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [POS_W-1:0]       POS_MAX = '1;

  logic [COUNT_WIDTH-1:0] line_cnt_r, line_cnt_nxt;
  logic [COUNT_WIDTH-1:0] len_cnt_r, len_cnt_nxt;
  logic [COUNT_WIDTH-1:0] ind_cnt_r, ind_cnt_nxt;
  logic                   ind_done_r, ind_done_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [POS_W-1:0]       word_pos_r, word_pos_nxt;
  logic [NUM_KW-1:0]      cand_r, cand_nxt;
  logic                   bs_odd_r, bs_odd_nxt;
  logic                   prev_bs_r, prev_bs_nxt;

  logic [NUM_KW-1:0]      exact_mask;
  logic [NUM_KW-1:0]      char_mask;
  logic [NUM_KW-1:0]      final_mask;
  logic                   byte_ws;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(logic [COUNT_WIDTH-1:0] v,
                                                     logic [2:0] amt);
    logic [COUNT_WIDTH-1:0] a;
    a = COUNT_WIDTH'(amt);
    sat_add = (v > CNT_MAX - a) ? CNT_MAX : v + a;
  endfunction

  function automatic logic [OUT_W-1:0] cap_out(logic [COUNT_WIDTH-1:0] v);
    cap_out = (v > COUNT_WIDTH'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(v);
  endfunction

  assign close   = (func == FUNC_END) || (text_byte == CH_NEWLINE);
  assign byte_ws = is_ws(text_byte);

  // Match keyword slots against the word so far and the current byte
  always_comb begin
    for (int i = 0; i < NUM_KW; i++) begin
      exact_mask[i] = cand_r[i] && (kw_len(KW_IDX_W'(i)) == word_pos_r);
      char_mask[i]  = cand_r[i] && (word_pos_r < kw_len(KW_IDX_W'(i))) &&
                      (kw_char(KW_IDX_W'(i), word_pos_r[2:0]) == text_byte);
    end
  end

  // Next line state
  always_comb begin
    line_cnt_nxt = line_cnt_r;
    len_cnt_nxt  = len_cnt_r;
    ind_cnt_nxt  = ind_cnt_r;
    ind_done_nxt = ind_done_r;
    phase_nxt    = phase_r;
    word_pos_nxt = word_pos_r;
    cand_nxt     = cand_r;
    bs_odd_nxt   = bs_odd_r;
    prev_bs_nxt  = prev_bs_r;
    if (close) begin
      // Start a new line; end marker also restarts line numbering
      line_cnt_nxt = (func == FUNC_END) ? '0 : sat_add(line_cnt_r, 3'd1);
      len_cnt_nxt  = '0;
      ind_cnt_nxt  = '0;
      ind_done_nxt = 1'b0;
      phase_nxt    = PH_SKIP;
      word_pos_nxt = '0;
      cand_nxt     = '1;
      bs_odd_nxt   = 1'b0;
      prev_bs_nxt  = 1'b0;
    end else begin
      len_cnt_nxt = sat_add(len_cnt_r, 3'd1);
      if (!ind_done_r) begin
        if (text_byte == CH_SPACE) begin
          ind_cnt_nxt = sat_add(ind_cnt_r, 3'd1);
        end else if (text_byte == CH_TAB) begin
          ind_cnt_nxt = sat_add(ind_cnt_r, 3'(TAB_STEP));
        end else begin
          ind_done_nxt = 1'b1;
        end
      end
      // Track the parity of the last backslash run
      if (text_byte == CH_BACKSLASH) begin
        bs_odd_nxt  = prev_bs_r ? !bs_odd_r : 1'b1;
        prev_bs_nxt = 1'b1;
      end else if (byte_ws) begin
        prev_bs_nxt = 1'b0;
      end else begin
        bs_odd_nxt  = 1'b0;
        prev_bs_nxt = 1'b0;
      end
      // Advance the first-word matcher
      if (byte_ws) begin
        if (phase_r == PH_WORD) begin
          cand_nxt  = exact_mask;
          phase_nxt = PH_DONE;
        end
      end else if (phase_r != PH_DONE) begin
        phase_nxt = PH_WORD;
        cand_nxt  = char_mask;
        if (word_pos_r != POS_MAX) begin
          word_pos_nxt = word_pos_r + 1'b1;
        end
      end
    end
  end

  // Result fields for the line being closed
  always_comb begin
    case (phase_r)
      PH_WORD: final_mask = exact_mask;
      PH_DONE: final_mask = cand_r;
      default: final_mask = '0;
    endcase
    res.keyword_code = KW_NONE;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (final_mask[i]) begin
        res.keyword_code = kw_code_t'(i + 1);
      end
    end
    res.line_index     = cap_out(line_cnt_r);
    res.line_bytes     = cap_out(len_cnt_r);
    res.indent_width   = cfg.indent_enable ? cap_out(ind_cnt_r) : '0;
    res.continues      = cfg.continuation_enable && bs_odd_r;
    res.too_many_lines = 32'(line_cnt_r) >= 32'(cfg.line_limit);
    res.final_line     = (func == FUNC_END);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r <= '0;
      len_cnt_r  <= '0;
      ind_cnt_r  <= '0;
      ind_done_r <= 1'b0;
      phase_r    <= PH_SKIP;
      word_pos_r <= '0;
      cand_r     <= '1;
      bs_odd_r   <= 1'b0;
      prev_bs_r  <= 1'b0;
    end else if (step) begin
      line_cnt_r <= line_cnt_nxt;
      len_cnt_r  <= len_cnt_nxt;
      ind_cnt_r  <= ind_cnt_nxt;
      ind_done_r <= ind_done_nxt;
      phase_r    <= phase_nxt;
      word_pos_r <= word_pos_nxt;
      cand_r     <= cand_nxt;
      bs_odd_r   <= bs_odd_nxt;
      prev_bs_r  <= prev_bs_nxt;
    end
  end

endmodule
